@@ sv/dcss_pkg.sv @@
// ----------------------------------------------------------------------------
// dcss_pkg
// Shared constants and helpers for the seven-segment display frame builder.
// ----------------------------------------------------------------------------
package dcss_pkg;

    localparam int unsigned VALUE_W     = 10;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned REM_W       = 7;
    localparam int unsigned ADDR_W      = 4;
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned BRIGHT_W    = 4;
    localparam int unsigned SCAN_W      = 3;
    localparam int unsigned CNT_W       = 3;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned S_TDATA_W   = 24;
    localparam int unsigned M_TDATA_W   = 16;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 10'd999;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_SCANNED = 2'd1;

    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 4'd15;
    localparam logic [SCAN_W-1:0]   SCAN_RESET   = 3'd7;

    // request kinds
    localparam logic REQ_INIT    = 1'b0;
    localparam logic REQ_DISPLAY = 1'b1;

    // driver register addresses
    localparam logic [ADDR_W-1:0] ADDR_DIGIT0    = 4'h1;
    localparam logic [ADDR_W-1:0] ADDR_DIGIT7    = 4'h8;
    localparam logic [ADDR_W-1:0] ADDR_DECODE    = 4'h9;
    localparam logic [ADDR_W-1:0] ADDR_INTENSITY = 4'hA;
    localparam logic [ADDR_W-1:0] ADDR_SCANLIM   = 4'hB;
    localparam logic [ADDR_W-1:0] ADDR_SHUTDOWN  = 4'hC;
    localparam logic [ADDR_W-1:0] ADDR_DISPTEST  = 4'hF;

    // last word position of each sequence
    localparam logic [CNT_W-1:0] INIT_LAST    = 3'd4;
    localparam logic [CNT_W-1:0] DISPLAY_LAST = 3'd7;

    localparam logic [DATA_W-1:0] SEG_BLANK = 8'h00;

    function automatic logic [DATA_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
        logic [DATA_W-1:0] pat;
        unique case (digit)
            4'd0:    pat = 8'h7E;
            4'd1:    pat = 8'h30;
            4'd2:    pat = 8'h6D;
            4'd3:    pat = 8'h79;
            4'd4:    pat = 8'h33;
            4'd5:    pat = 8'h5B;
            4'd6:    pat = 8'h5F;
            4'd7:    pat = 8'h70;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h7B;
            default: pat = SEG_BLANK;
        endcase
        return pat;
    endfunction

endpackage

@@ sv/dual_counter_seven_segment_frame_top.sv @@
// ----------------------------------------------------------------------------
// dual_counter_seven_segment_frame_top
// Builds driver register-write words for an eight-digit seven-segment display.
// ----------------------------------------------------------------------------
// Slave stream takes one request per item: tuser is the kind (0 init,
// 1 display), tdata carries the up and down values. Master stream gives one
// register word per item, tlast on the final word of each sequence.
// Init emits shutdown, display test, decode, intensity and scan limit words.
// Display emits digits 7 down to 0: down value, two blanks, up value.
// Values above 999 show as 999.
// A taken request is held in the sequence control; its first word is then
// loaded into the output register. One word per cycle while i_m_tready is
// high; the word counter ends a display request after 8 words and an init after 5.
// The next request is taken in the cycle its predecessor's last word is
// loaded, so sequences follow each other without gaps.
// The output register holds its word while i_m_tready is low; the word
// counter and s-side ready stall with it.
// Reset clears the counter, the output valid and sets brightness to 15 and
// scan limit to 7. The config channel is always ready; an index beyond the
// two registers is ignored.
// ----------------------------------------------------------------------------
module dual_counter_seven_segment_frame_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [9:0] up_value, [19:10] down_value, [23:20] zero
    input  logic [dcss_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // [0] req_type
    input  logic                               i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [3:0] reg_addr, [11:4] reg_data, [15:12] zero
    output logic [dcss_pkg::M_TDATA_W-1:0]     o_m_tdata,
    output logic                               o_m_tlast,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dcss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dcss_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int unsigned VW = dcss_pkg::VALUE_W;
    localparam int unsigned DW = dcss_pkg::DIGIT_W;
    localparam int unsigned RW = dcss_pkg::REM_W;
    localparam int unsigned CW = dcss_pkg::CNT_W;

    // config
    logic [dcss_pkg::BRIGHT_W-1:0] r_bright;
    logic [dcss_pkg::SCAN_W-1:0]   r_scan;

    // sequence control
    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic          r_kind;

    // held digits: hundreds and the remainder below 100 for each value
    logic [DW-1:0] r_down_h;
    logic [RW-1:0] r_down_r;
    logic [DW-1:0] r_up_h;
    logic [RW-1:0] r_up_r;

    // output register
    logic                          r_ovalid;
    logic [dcss_pkg::ADDR_W-1:0]   r_addr;
    logic [dcss_pkg::DATA_W-1:0]   r_data;
    logic                          r_olast;

    logic          w_adv;
    logic          w_emit;
    logic          w_word_last;
    logic          w_s_acc;
    logic [DW-1:0] w_in_down_h;
    logic [RW-1:0] w_in_down_r;
    logic [DW-1:0] w_in_up_h;
    logic [RW-1:0] w_in_up_r;

    logic [dcss_pkg::ADDR_W-1:0] w_addr;
    logic [dcss_pkg::DATA_W-1:0] w_data;
    logic [RW-1:0]               w_sel_r;
    logic [DW-1:0]               w_sel_h;
    logic [13:0]                 w_tens_prod;
    logic [DW-1:0]               w_tens;
    logic [DW-1:0]               w_ones;

    // saturate, then hundreds by reciprocal multiply (x*41 >> 12, exact below 1000)
    function automatic logic [DW+RW-1:0] split_hundreds(input logic [VW-1:0] v);
        logic [VW-1:0] x;
        logic [15:0]   prod;
        logic [DW-1:0] h;
        logic [VW-1:0] hx100;
        logic [VW-1:0] r;
        x     = (v > dcss_pkg::VALUE_MAX) ? dcss_pkg::VALUE_MAX : v;
        prod  = 16'(x) * 16'd41;
        h     = prod[15:12];
        hx100 = VW'(h) * VW'(100);
        r     = x - hx100;
        return {h, r[RW-1:0]};
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= dcss_pkg::BRIGHT_RESET;
            r_scan   <= dcss_pkg::SCAN_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == dcss_pkg::CFG_BRIGHTNESS) begin
                r_bright <= i_cfg_data[dcss_pkg::BRIGHT_W-1:0];
            end else if (i_cfg_index == dcss_pkg::CFG_DIGITS_SCANNED) begin
                r_scan <= i_cfg_data[dcss_pkg::SCAN_W-1:0];
            end
        end
    end

    assign w_adv       = !r_ovalid || i_m_tready;
    assign w_emit      = r_busy && w_adv;
    assign w_word_last = (r_kind == dcss_pkg::REQ_INIT) ? (r_cnt == dcss_pkg::INIT_LAST)
                                                        : (r_cnt == dcss_pkg::DISPLAY_LAST);
    assign o_s_tready  = !r_busy || (w_adv && w_word_last);
    assign w_s_acc     = i_s_tvalid && o_s_tready;

    assign {w_in_up_h, w_in_up_r}     = split_hundreds(i_s_tdata[VW-1:0]);
    assign {w_in_down_h, w_in_down_r} = split_hundreds(i_s_tdata[2*VW-1:VW]);

    // tens and ones of the remainder that this word needs
    assign w_sel_r     = (r_cnt > 3'd4) ? r_up_r : r_down_r;
    assign w_sel_h     = (r_cnt > 3'd4) ? r_up_h : r_down_h;
    assign w_tens_prod = 14'(w_sel_r) * 14'd103;
    assign w_tens      = w_tens_prod[13:10];
    assign w_ones      = DW'(w_sel_r - (RW'(w_tens) * RW'(10)));

    always_comb begin
        w_addr = '0;
        w_data = '0;
        if (r_kind == dcss_pkg::REQ_INIT) begin
            unique case (r_cnt)
                3'd0: begin
                    w_addr = dcss_pkg::ADDR_SHUTDOWN;
                    w_data = 8'd1;
                end
                3'd1: begin
                    w_addr = dcss_pkg::ADDR_DISPTEST;
                    w_data = 8'd0;
                end
                3'd2: begin
                    w_addr = dcss_pkg::ADDR_DECODE;
                    w_data = 8'd0;
                end
                3'd3: begin
                    w_addr = dcss_pkg::ADDR_INTENSITY;
                    w_data = dcss_pkg::DATA_W'(r_bright);
                end
                default: begin
                    w_addr = dcss_pkg::ADDR_SCANLIM;
                    w_data = dcss_pkg::DATA_W'(r_scan);
                end
            endcase
        end else begin
            w_addr = dcss_pkg::ADDR_DIGIT7 - dcss_pkg::ADDR_W'(r_cnt);
            unique case (r_cnt)
                3'd0, 3'd5: w_data = dcss_pkg::seg_pattern(w_sel_h);
                3'd1, 3'd6: w_data = dcss_pkg::seg_pattern(w_tens);
                3'd2, 3'd7: w_data = dcss_pkg::seg_pattern(w_ones);
                default:    w_data = dcss_pkg::SEG_BLANK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_cnt <= r_cnt + 3'd1;
                if (w_word_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_s_acc) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
            if (w_adv) begin
                r_ovalid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_kind   <= i_s_tuser;
            r_down_h <= w_in_down_h;
            r_down_r <= w_in_down_r;
            r_up_h   <= w_in_up_h;
            r_up_r   <= w_in_up_r;
        end
        if (w_emit) begin
            r_addr  <= w_addr;
            r_data  <= w_data;
            r_olast <= w_word_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {4'd0, r_data, r_addr};
    assign o_m_tlast  = r_olast;

endmodule

@@ sv/dcss_checker.sv @@
// ----------------------------------------------------------------------------
// dcss_checker
// Port-level checks for the seven-segment display frame builder.
// ----------------------------------------------------------------------------
module dcss_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [dcss_pkg::M_TDATA_W-1:0]     o_m_tdata,
    input logic                               o_m_tlast,
    input logic                               o_cfg_ready
);

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tlast)))
        else $error("stalled output word changed");

    // a reset leaves no word on the output
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // sequences end on digit 0 or on the scan limit word
    a_last_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |->
            (o_m_tdata[3:0] == dcss_pkg::ADDR_DIGIT0
             || o_m_tdata[3:0] == dcss_pkg::ADDR_SCANLIM))
        else $error("last word at wrong address");

    // no sequence stops early
    a_not_last_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |->
            (o_m_tdata[3:0] != dcss_pkg::ADDR_DIGIT0
             && o_m_tdata[3:0] != dcss_pkg::ADDR_SCANLIM))
        else $error("closing address without last flag");

    a_cfg_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_cfg_ready)
        else $error("config channel not ready");

endmodule

bind dual_counter_seven_segment_frame_top dcss_checker u_dcss_checker (.*);

@@ sim/dual_counter_seven_segment_frame_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_counter_seven_segment_frame_top_tb
// Drives init and display requests into the frame builder and checks every
// register word against a predictor of the expected word sequence. Random
// requests run under several idle and stall mixes, with one long output
// hold-off and config changes between phases.
// ----------------------------------------------------------------------------
module dual_counter_seven_segment_frame_top_tb;

    import dcss_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned TAIL_CYCLES   = 20;
    localparam int unsigned PHASE_ITEMS   = 80;

    // indexes outside the register list, the block must ignore them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [DATA_W-1:0] SEGMENTS [10] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
    };

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              last;
    } reg_word_t;

    class frame_scoreboard;
        logic [BRIGHT_W-1:0] brightness = BRIGHT_RESET;
        logic [SCAN_W-1:0]   scan_digits = SCAN_RESET;
        reg_word_t           expected_words[$];
        int unsigned         mismatches = 0;

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_BRIGHTNESS)
                brightness = value[BRIGHT_W-1:0];
            else if (idx == CFG_DIGITS_SCANNED)
                scan_digits = value[SCAN_W-1:0];
        endfunction

        function void push_word(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data,
                                logic last);
            reg_word_t w;
            w.addr = addr;
            w.data = data;
            w.last = last;
            expected_words.push_back(w);
        endfunction

        // one accepted request: queue the whole word sequence it must produce
        function void note_request(logic kind, logic [VALUE_W-1:0] up_val,
                                   logic [VALUE_W-1:0] down_val);
            int unsigned left_val;
            int unsigned right_val;
            logic [DIGIT_W-1:0] digits [6];
            logic [DATA_W-1:0] data;
            if (kind == REQ_INIT) begin
                push_word(ADDR_SHUTDOWN, 8'd1, 1'b0);
                push_word(ADDR_DISPTEST, 8'd0, 1'b0);
                push_word(ADDR_DECODE, 8'd0, 1'b0);
                push_word(ADDR_INTENSITY, DATA_W'(brightness), 1'b0);
                push_word(ADDR_SCANLIM, DATA_W'(scan_digits), 1'b1);
                return;
            end
            // values past the three-digit range show as 999
            left_val  = (down_val > VALUE_MAX) ? VALUE_MAX : down_val;
            right_val = (up_val > VALUE_MAX) ? VALUE_MAX : up_val;
            digits[0] = DIGIT_W'(left_val / 100);
            digits[1] = DIGIT_W'((left_val / 10) % 10);
            digits[2] = DIGIT_W'(left_val % 10);
            digits[3] = DIGIT_W'(right_val / 100);
            digits[4] = DIGIT_W'((right_val / 10) % 10);
            digits[5] = DIGIT_W'(right_val % 10);
            for (int k = 0; k < 8; k++) begin
                if (k < 3)
                    data = SEGMENTS[digits[k]];
                else if (k < 5)
                    data = SEG_BLANK;
                else
                    data = SEGMENTS[digits[k-2]];
                push_word(ADDR_DIGIT7 - ADDR_W'(k), data, k == 7);
            end
        endfunction

        function void check_word(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data,
                                 logic last);
            reg_word_t w;
            if (expected_words.size() == 0) begin
                $error("unexpected word addr %h data %h last %b", addr, data, last);
                mismatches++;
                return;
            end
            w = expected_words.pop_front();
            if (addr !== w.addr) begin
                $error("reg_addr expected %h got %h", w.addr, addr);
                mismatches++;
            end
            if (data !== w.data) begin
                $error("reg_data expected %h got %h", w.data, data);
                mismatches++;
            end
            if (last !== w.last) begin
                $error("last_word expected %b got %b", w.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [S_TDATA_W-1:0]    i_s_tdata;
    logic                    i_s_tuser;
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    logic [M_TDATA_W-1:0]    o_m_tdata;
    logic                    o_m_tlast;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    frame_scoreboard sb;
    int unsigned     send_idle_pct = 0;
    int unsigned     recv_stall_pct = 0;
    int unsigned     hold_left = 0;
    bit              hold_go = 1'b0;
    int unsigned     cycle_count = 0;

    dual_counter_seven_segment_frame_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // output side: check accepted words, then choose next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_word(o_m_tdata[ADDR_W-1:0], o_m_tdata[ADDR_W +: DATA_W], o_m_tlast);
        if (hold_go) begin
            hold_left = LONG_HOLD;
            hold_go = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // valid stays high from one item to the next unless an idle cycle is drawn
    task automatic send_request(input logic kind, input logic [VALUE_W-1:0] up_val,
                                input logic [VALUE_W-1:0] down_val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {4'b0, down_val, up_val};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(kind, up_val, down_val);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return VALUE_W'($urandom_range(999));
        else if (sel < 85)
            return VALUE_W'($urandom_range(1023, 1000));
        else
            return VALUE_W'($urandom_range(1023));
    endfunction

    task automatic send_random();
        logic kind;
        logic [VALUE_W-1:0] up_val;
        logic [VALUE_W-1:0] down_val;
        kind     = ($urandom_range(99) < 20) ? REQ_INIT : REQ_DISPLAY;
        up_val   = pick_value();
        down_val = pick_value();
        send_request(kind, up_val, down_val);
    endtask

    task automatic drain_outputs();
        i_s_tvalid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.apply_reg(idx, value);
    endtask

    initial begin
        sb = new;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= REQ_INIT;
        i_m_tready  <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_BRIGHTNESS;
        i_cfg_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, digit table, saturation and alternating bit patterns
        send_request(REQ_INIT, 10'd0, 10'd0);
        send_request(REQ_DISPLAY, 10'd0, 10'd0);
        send_request(REQ_DISPLAY, 10'd999, 10'd999);
        send_request(REQ_DISPLAY, 10'd123, 10'd456);
        send_request(REQ_DISPLAY, 10'd789, 10'd900);
        send_request(REQ_DISPLAY, 10'd1023, 10'd1000);
        send_request(REQ_DISPLAY, 10'd1000, 10'd341);
        send_request(REQ_DISPLAY, 10'd682, 10'd1023);
        send_request(REQ_DISPLAY, 10'd341, 10'd682);
        send_request(REQ_INIT, 10'd1023, 10'd1023);
        drain_outputs();

        // lowest settings, spare indexes must not disturb them
        write_reg(CFG_BRIGHTNESS, 8'd0);
        write_reg(CFG_DIGITS_SCANNED, 8'd0);
        write_reg(CFG_SPARE_A, 8'hFF);
        write_reg(CFG_SPARE_B, 8'hA5);
        i_cfg_valid <= 1'b0;
        send_request(REQ_INIT, 10'd0, 10'd0);
        send_request(REQ_DISPLAY, 10'd50, 10'd607);
        send_request(REQ_INIT, 10'd512, 10'd256);
        drain_outputs();

        // bits above each register's width are dropped
        write_reg(CFG_BRIGHTNESS, 8'hFF);
        write_reg(CFG_DIGITS_SCANNED, 8'hFF);
        i_cfg_valid <= 1'b0;
        send_request(REQ_INIT, 10'd0, 10'd0);
        send_request(REQ_DISPLAY, 10'd8, 10'd1012);
        send_request(REQ_INIT, 10'd0, 10'd0);
        drain_outputs();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 48;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 48;
                end
                default: begin
                    send_idle_pct = 8;
                    recv_stall_pct = 8;
                end
            endcase
            write_reg(CFG_BRIGHTNESS, CFG_DATA_W'($urandom_range(255)));
            write_reg(CFG_DIGITS_SCANNED, CFG_DATA_W'($urandom_range(255)));
            i_cfg_valid <= 1'b0;
            // long output hold-off so the block backs up into its input
            if (phase == 0)
                hold_go = 1'b1;
            repeat (PHASE_ITEMS) send_random();
            drain_outputs();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
